// ===== design/dmx_rgb_dimmer_strobe_top_defines.svh =====
//------------------------------------------------------------------------------
// dmx rgb dimmer strobe assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
//------------------------------------------------------------------------------
`ifndef DMX_RGB_DIMMER_STROBE_TOP_DEFINES_SVH
`define DMX_RGB_DIMMER_STROBE_TOP_DEFINES_SVH

// same-cycle implication
`define DMXRGB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DMXRGB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dmxrgb_pkg.sv =====
//------------------------------------------------------------------------------
// dmxrgb_pkg
// types, codes and constants of the dmx rgb dimmer with strobe
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmxrgb_pkg;

  localparam int unsigned SLOT_COUNT = 6;
  localparam logic [9:0] ELAPSED_MAX = 10'd1023;
  localparam logic [9:0] START_ADDR_RESET = 10'd1;
  localparam logic [9:0] PERIOD_RESET = 10'd1000;
  localparam logic [7:0] DUTY_MAX = 8'd255;

  // slot positions inside the fixture window
  localparam logic [2:0] SLOT_DIMMER = 3'd0;
  localparam logic [2:0] SLOT_RED    = 3'd1;
  localparam logic [2:0] SLOT_GREEN  = 3'd2;
  localparam logic [2:0] SLOT_BLUE   = 3'd3;
  localparam logic [2:0] SLOT_STROBE = 3'd4;
  localparam logic [2:0] SLOT_CORR   = 3'd5;

  typedef enum logic [1:0] {
    MODE_SLOT      = 2'd0,
    MODE_FRAME_END = 2'd1,
    MODE_TIMEOUT   = 2'd2,
    MODE_TICK      = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_MUL,
    SC_CHK,
    SC_DIV,
    SC_HOLD
  } scale_state_t;

  // operands handed to the scaler at frame end
  typedef struct packed {
    logic [6:0] dim;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] corr;
  } scale_ops_t;

  typedef struct packed {
    logic go;
    logic zero;
  } scale_cmd_t;

  // 1000 / k for k = 1 .. 30
  function automatic logic [9:0] strobe_period(input logic [4:0] k);
    logic [9:0] p;
    unique case (k)
      5'd1:  p = 10'd1000;
      5'd2:  p = 10'd500;
      5'd3:  p = 10'd333;
      5'd4:  p = 10'd250;
      5'd5:  p = 10'd200;
      5'd6:  p = 10'd166;
      5'd7:  p = 10'd142;
      5'd8:  p = 10'd125;
      5'd9:  p = 10'd111;
      5'd10: p = 10'd100;
      5'd11: p = 10'd90;
      5'd12: p = 10'd83;
      5'd13: p = 10'd76;
      5'd14: p = 10'd71;
      5'd15: p = 10'd66;
      5'd16: p = 10'd62;
      5'd17: p = 10'd58;
      5'd18: p = 10'd55;
      5'd19: p = 10'd52;
      5'd20: p = 10'd50;
      5'd21: p = 10'd47;
      5'd22: p = 10'd45;
      5'd23: p = 10'd43;
      5'd24: p = 10'd41;
      5'd25: p = 10'd40;
      5'd26: p = 10'd38;
      5'd27: p = 10'd37;
      5'd28: p = 10'd35;
      5'd29: p = 10'd34;
      5'd30: p = 10'd33;
      default: p = PERIOD_RESET;
    endcase
    return p;
  endfunction

endpackage

// ===== design/dmxrgb_regs.sv =====
//------------------------------------------------------------------------------
// dmxrgb_regs
// fixture slot window, start address, strobe level, gate and ms timer
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmxrgb_regs
  import dmxrgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [9:0] cfg_wr_data,
  input  logic       accept,
  input  mode_t      mode,
  input  logic [9:0] slot_index,
  input  logic [7:0] slot_value,
  output scale_ops_t ops
);

  logic [7:0] slots_r [SLOT_COUNT];
  logic [9:0] start_r;
  logic [7:0] strobe_r;
  logic [9:0] period_r;
  logic       gate_r;
  logic [9:0] elapsed_r;

  logic [9:0]  offset;
  logic        in_window;
  logic [12:0] strobe_x29;
  logic [12:0] strobe_q;
  logic [4:0]  strobe_k;
  logic [9:0]  elapsed_inc;
  logic        gate_eff;
  logic        toggle;

  assign offset    = slot_index - start_r;
  assign in_window = (slot_index >= start_r) && (offset < 10'(SLOT_COUNT));

  // x / 255 as (x + (x >> 8) + 1) >> 8, exact for the 13-bit x used here
  assign strobe_x29 = 13'(slots_r[SLOT_STROBE]) * 13'd29;
  assign strobe_q   = (strobe_x29 + (strobe_x29 >> 8) + 13'd1) >> 8;
  assign strobe_k   = strobe_q[4:0] + 5'd1;

  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? ELAPSED_MAX : elapsed_r + 10'd1;
  assign toggle      = (strobe_r != 8'd0) && (elapsed_inc > period_r);

  // gate as it stands after the frame-end update
  assign gate_eff = gate_r || (slots_r[SLOT_STROBE] == 8'd0);

  assign ops.dim   = gate_eff ? slots_r[SLOT_DIMMER][7:1] : 7'd0;
  assign ops.red   = slots_r[SLOT_RED];
  assign ops.green = slots_r[SLOT_GREEN];
  assign ops.blue  = slots_r[SLOT_BLUE];
  assign ops.corr  = slots_r[SLOT_CORR];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots_r[i] <= 8'd0;
      end
      start_r   <= START_ADDR_RESET;
      strobe_r  <= 8'd0;
      period_r  <= PERIOD_RESET;
      gate_r    <= 1'b0;
      elapsed_r <= 10'd0;
    end else begin
      if (cfg_wr_en) begin
        start_r <= cfg_wr_data;
      end
      if (accept) begin
        unique case (mode)
          MODE_SLOT: begin
            if (in_window) begin
              slots_r[offset[2:0]] <= slot_value;
            end
          end
          MODE_FRAME_END: begin
            strobe_r <= slots_r[SLOT_STROBE];
            period_r <= strobe_period(strobe_k);
            gate_r   <= gate_eff;
          end
          MODE_TIMEOUT: begin
          end
          MODE_TICK: begin
            if (toggle) begin
              gate_r    <= ~gate_r;
              elapsed_r <= 10'd0;
            end else begin
              elapsed_r <= elapsed_inc;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== design/dmxrgb_scaler.sv =====
//------------------------------------------------------------------------------
// dmxrgb_scaler
// duty sequencer around one shared multiplier and a radix-2 divide step
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "dmx_rgb_dimmer_strobe_top_defines.svh"

module dmxrgb_scaler
  import dmxrgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  scale_cmd_t cmd,
  input  scale_ops_t ops,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red_duty,
  output logic [7:0] out_green_duty,
  output logic [7:0] out_blue_duty
);

  scale_state_t state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [6:0]  dim_r, dim_nxt;
  logic [7:0]  col_r [3];
  logic [7:0]  col_nxt [3];
  logic [7:0]  div_r, div_nxt;
  logic [14:0] prod_r, prod_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  quo_r, quo_nxt;
  logic [7:0]  red_r, red_nxt;
  logic [7:0]  green_r, green_nxt;
  logic [7:0]  blue_r, blue_nxt;
  logic [7:0]  out_red_r, out_red_nxt;
  logic [7:0]  out_green_r, out_green_nxt;
  logic [7:0]  out_blue_r, out_blue_nxt;

  logic [14:0] mul;
  logic [9:0]  trial;
  logic        borrow;
  logic        load_out;

  assign mul    = 15'(dim_r) * 15'(col_r[cnt_r[1:0]]);
  assign trial  = {1'b0, rem_r, quo_r[7]} - {2'b00, div_r};
  assign borrow = trial[9];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    dim_nxt       = dim_r;
    col_nxt       = col_r;
    div_nxt       = div_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    load_out      = 1'b0;

    unique case (state_r)
      SC_IDLE: begin
        if (cmd.go) begin
          dim_nxt    = ops.dim;
          col_nxt[0] = ops.red;
          col_nxt[1] = ops.green;
          col_nxt[2] = ops.blue;
          div_nxt    = (ops.corr == 8'd0) ? 8'd1 : ops.corr;
          cnt_nxt    = 3'd0;
          if (cmd.zero) begin
            red_nxt   = 8'd0;
            green_nxt = 8'd0;
            blue_nxt  = 8'd0;
            state_nxt = SC_HOLD;
          end else begin
            state_nxt = SC_MUL;
          end
        end
      end
      SC_MUL: begin
        priority case (cnt_r)
          3'd0: prod_nxt  = mul;
          3'd1: green_nxt = {1'b0, mul[14:8]};
          default: begin
            blue_nxt  = {1'b0, mul[14:8]};
            state_nxt = SC_CHK;
          end
        endcase
        cnt_nxt = (cnt_r == 3'd2) ? 3'd0 : cnt_r + 3'd1;
      end
      SC_CHK: begin
        // red = floor((prod / 2) / corr); quotient past 255 saturates
        if ({2'b00, prod_r[14:9]} >= div_r) begin
          red_nxt   = DUTY_MAX;
          state_nxt = SC_HOLD;
        end else begin
          rem_nxt   = {2'b00, prod_r[14:9]};
          quo_nxt   = prod_r[8:1];
          cnt_nxt   = 3'd0;
          state_nxt = SC_DIV;
        end
      end
      SC_DIV: begin
        rem_nxt = borrow ? {rem_r[6:0], quo_r[7]} : trial[7:0];
        quo_nxt = {quo_r[6:0], ~borrow};
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          red_nxt   = {quo_r[6:0], ~borrow};
          state_nxt = SC_HOLD;
        end
      end
      SC_HOLD: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = SC_IDLE;
        end
      end
      default: state_nxt = SC_IDLE;
    endcase

    out_valid_nxt = (out_valid_r && out_stall) || load_out;
    out_red_nxt   = load_out ? red_r   : out_red_r;
    out_green_nxt = load_out ? green_r : out_green_r;
    out_blue_nxt  = load_out ? blue_r  : out_blue_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SC_IDLE;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dim_r       <= dim_nxt;
    col_r       <= col_nxt;
    div_r       <= div_nxt;
    prod_r      <= prod_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    red_r       <= red_nxt;
    green_r     <= green_nxt;
    blue_r      <= blue_nxt;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
  end

  assign busy           = (state_r != SC_IDLE);
  assign out_valid      = out_valid_r;
  assign out_red_duty   = out_red_r;
  assign out_green_duty = out_green_r;
  assign out_blue_duty  = out_blue_r;

  `DMXRGB_ASSERT_NOW(a_rem_below_div, state_r == SC_DIV, rem_r < div_r, "remainder not below divisor")
  `DMXRGB_ASSERT_NOW(a_mul_cnt, state_r == SC_MUL, cnt_r <= 3'd2, "multiply step out of range")
  `DMXRGB_ASSERT_NEXT(a_div_ends, state_r == SC_DIV && cnt_r == 3'd7, state_r == SC_HOLD, "divide did not finish")
  `DMXRGB_ASSERT_NEXT(a_load_valid, state_r == SC_HOLD && (!out_valid_r || !out_stall), out_valid_r && state_r == SC_IDLE, "result beat not loaded")

endmodule

// ===== design/dmx_rgb_dimmer_strobe_top.sv =====
// result path: a frame-end beat passes the multiply, range-check, divide and hold states,
//   a timeout beat only the hold state; the divide is skipped when red saturates
// throughput: slot and tick beats every cycle while the scaler is idle; a frame end holds
//   the input through 3 passes through the shared multiplier, a range check and 8 divide
//   steps for red, plus any wait of the result on out_stall (a timeout only its hold state)
// reset: rst_n is synchronous, active low; slots, strobe and timer clear, start address 1
//------------------------------------------------------------------------------
// dmx_rgb_dimmer_strobe_top
// dmx rgb dimmer with strobe: slot window, strobe timer and duty scaler
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmx_rgb_dimmer_strobe_top
  import dmxrgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [9:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [9:0] in_slot_index,
  input  logic [7:0] in_slot_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red_duty,
  output logic [7:0] out_green_duty,
  output logic [7:0] out_blue_duty
);

  logic       busy;
  logic       accept;
  mode_t      mode;
  scale_ops_t ops;
  scale_cmd_t cmd;

  assign mode     = mode_t'(in_mode);
  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  assign cmd.go   = accept && ((mode == MODE_FRAME_END) || (mode == MODE_TIMEOUT));
  assign cmd.zero = (mode == MODE_TIMEOUT);

  dmxrgb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .mode        (mode),
    .slot_index  (in_slot_index),
    .slot_value  (in_slot_value),
    .ops         (ops)
  );

  dmxrgb_scaler u_scaler (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .ops            (ops),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red_duty   (out_red_duty),
    .out_green_duty (out_green_duty),
    .out_blue_duty  (out_blue_duty)
  );

endmodule

// ===== test/tb_dmx_rgb_dimmer_strobe_top.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_dmx_rgb_dimmer_strobe_top
// drives slot, frame-end, timeout and tick beats through the dimmer with random
// sender gaps and receiver stalls, predicts every duty beat in a scoreboard and
// compares the red, green and blue duties in order across several start addresses
//------------------------------------------------------------------------------

module tb_dmx_rgb_dimmer_strobe_top;
  import dmxrgb_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } duty_set_t;

  class duty_scoreboard;
    logic [7:0] slots [SLOT_COUNT];
    logic [7:0] strobe_level;
    logic       gate;
    logic [9:0] elapsed_ms;
    logic [9:0] start_addr;
    duty_set_t  pending_duties [$];
    int         errors;

    function new();
      foreach (slots[i]) slots[i] = 8'd0;
      strobe_level = 8'd0;
      gate         = 1'b0;
      elapsed_ms   = 10'd0;
      start_addr   = START_ADDR_RESET;
      errors       = 0;
    endfunction

    function void set_start(logic [9:0] addr);
      start_addr = addr;
    endfunction

    // updates the fixture state for one accepted beat; returns 0 for a slot byte
    // that falls outside the window and so changes nothing
    function bit note_beat(mode_t m, logic [9:0] idx, logic [7:0] val);
      int          offset;
      int unsigned dim, corr, red, period;
      duty_set_t   duty;
      case (m)
        MODE_SLOT: begin
          offset = int'(idx) - int'(start_addr);
          if (offset < 0 || offset >= SLOT_COUNT) return 1'b0;
          slots[offset] = val;
        end
        MODE_FRAME_END: begin
          dim  = slots[SLOT_DIMMER] / 2;
          corr = slots[SLOT_CORR];
          strobe_level = slots[SLOT_STROBE];
          if (strobe_level == 8'd0) gate = 1'b1;
          if (corr == 0) corr = 1;
          red = (dim * slots[SLOT_RED] * gate * 128) / corr / 256;
          if (red > 255) red = 255;
          duty.red   = red[7:0];
          duty.green = 8'((dim * slots[SLOT_GREEN] * gate) / 256);
          duty.blue  = 8'((dim * slots[SLOT_BLUE] * gate) / 256);
          pending_duties.push_back(duty);
        end
        MODE_TIMEOUT: begin
          pending_duties.push_back('0);
        end
        default: begin
          if (elapsed_ms < ELAPSED_MAX) elapsed_ms = elapsed_ms + 10'd1;
          if (strobe_level != 8'd0) begin
            period = 1000 / ((int'(strobe_level) * 29) / 255 + 1);
            if (int'(elapsed_ms) > period) begin
              gate       = ~gate;
              elapsed_ms = 10'd0;
            end
          end
        end
      endcase
      return 1'b1;
    endfunction

    task report(string msg);
      $display("[%0t] duty mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_duties(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      duty_set_t want;
      if (pending_duties.size() == 0) begin
        report($sformatf("unexpected beat r=%0d g=%0d b=%0d", red, green, blue));
        return;
      end
      want = pending_duties.pop_front();
      if (red !== want.red)
        report($sformatf("red got %0d want %0d", red, want.red));
      if (green !== want.green)
        report($sformatf("green got %0d want %0d", green, want.green));
      if (blue !== want.blue)
        report($sformatf("blue got %0d want %0d", blue, want.blue));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [9:0] cfg_wr_data = 10'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_mode = MODE_SLOT;
  logic [9:0] in_slot_index = 10'd0;
  logic [7:0] in_slot_value = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_red_duty;
  logic [7:0] out_green_duty;
  logic [7:0] out_blue_duty;

  duty_scoreboard sb = new();
  int burst_left = 0;
  int beats_counted = 0;
  int rx_style = 0;
  int rx_count = 0;
  int rx_run = 0;

  dmx_rgb_dimmer_strobe_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_slot_index  (in_slot_index),
    .in_slot_value  (in_slot_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red_duty   (out_red_duty),
    .out_green_duty (out_green_duty),
    .out_blue_duty  (out_blue_duty)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver stall pattern: free-running, coin toss, or long stall runs
  always @(negedge clk) begin
    if (rx_count == 0) begin
      rx_style = $urandom_range(0, 2);
      rx_count = $urandom_range(100, 400);
    end
    rx_count--;
    case (rx_style)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_run == 0) begin
          out_stall <= ~out_stall;
          rx_run = out_stall ? $urandom_range(1, 8) : $urandom_range(1, 12);
        end else begin
          rx_run--;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_duties(out_red_duty, out_green_duty, out_blue_duty);
  end

  task send_beat(mode_t m, logic [9:0] idx, logic [7:0] val);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(100, 200);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_slot_index <= idx;
    in_slot_value <= val;
    do @(posedge clk); while (in_stall);
    void'(sb.note_beat(m, idx, val));
    beats_counted++;
  endtask

  // beats that ignore the slot fields carry random junk there
  task send_event(mode_t m);
    send_beat(m, 10'($urandom_range(0, 512)), 8'($urandom_range(0, 255)));
  endtask

  // slot and tick beats give no result, so allow the longest frame-end latency
  // after the last duty beat before treating the block as idle
  task wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending_duties.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    burst_left = 0;
  endtask

  task write_start(logic [9:0] addr);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    @(posedge clk);
    sb.set_start(addr);
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] pick_slot_value(int pos);
    int r;
    r = $urandom_range(0, 3);
    if (pos == SLOT_STROBE) begin
      if (r == 0) return 8'd0;
      if (r == 1) return 8'($urandom_range(200, 255));
      if (r == 2) return 8'd255;
      return 8'($urandom_range(0, 255));
    end
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  task run_frame();
    int unsigned base, n_slots, n_ticks, idx;
    base = sb.start_addr;
    send_beat(MODE_SLOT, 10'd0, 8'($urandom_range(0, 255)));
    // short frames leave the older slot values in place
    n_slots = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : SLOT_COUNT;
    for (int k = 0; k < n_slots; k++) begin
      idx = base + k;
      if (idx <= 512) send_beat(MODE_SLOT, 10'(idx), pick_slot_value(k));
    end
    if ($urandom_range(0, 2) == 0 && base >= 1 && base <= 513)
      send_beat(MODE_SLOT, 10'(base - 1), 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 2) == 0 && base + 6 <= 512)
      send_beat(MODE_SLOT, 10'(base + 6), 8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 3))
      send_beat(MODE_SLOT, 10'($urandom_range(0, 512)), 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0) begin
      send_event(MODE_TIMEOUT);
      if ($urandom_range(0, 1) == 0) return;
    end
    send_event(MODE_FRAME_END);
    case ($urandom_range(0, 3))
      0: n_ticks = 0;
      1: n_ticks = $urandom_range(1, 10);
      2: n_ticks = $urandom_range(20, 60);
      default: n_ticks = $urandom_range(34, 130);
    endcase
    repeat (n_ticks) send_event(MODE_TICK);
    if ($urandom_range(0, 15) == 0) send_event(MODE_TIMEOUT);
  endtask

  // elapsed time saturates with strobe off, then the slowest strobe flips at once
  task run_saturated_timer();
    send_beat(MODE_SLOT, 10'(sb.start_addr + SLOT_STROBE), 8'd0);
    send_event(MODE_FRAME_END);
    repeat (1030) send_event(MODE_TICK);
    send_beat(MODE_SLOT, 10'(sb.start_addr + SLOT_STROBE), 8'd1);
    send_event(MODE_FRAME_END);
    repeat (3) send_event(MODE_TICK);
    send_event(MODE_FRAME_END);
  endtask

  initial begin
    logic [9:0] starts [7];
    int goal;
    starts = '{10'd0, 10'd512, 10'd507, 10'd1023, 10'd0, 10'd0, 10'd1};
    starts[4] = 10'($urandom_range(2, 506));
    starts[5] = 10'($urandom_range(1, 512));
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    write_start(10'd1);
    // directed: empty frame, timeout, tick, saturated red, window edges, dim floor
    send_event(MODE_FRAME_END);
    send_event(MODE_TIMEOUT);
    send_event(MODE_TICK);
    send_beat(MODE_SLOT, 10'd0, 8'hAA);
    send_beat(MODE_SLOT, 10'd1, 8'd255);
    send_beat(MODE_SLOT, 10'd2, 8'd255);
    send_beat(MODE_SLOT, 10'd3, 8'd255);
    send_beat(MODE_SLOT, 10'd4, 8'd255);
    send_beat(MODE_SLOT, 10'd5, 8'd0);
    send_beat(MODE_SLOT, 10'd6, 8'd0);
    send_event(MODE_FRAME_END);
    send_beat(MODE_SLOT, 10'd7, 8'h55);
    send_beat(MODE_SLOT, 10'd512, 8'd255);
    send_beat(MODE_SLOT, 10'd6, 8'd255);
    send_event(MODE_FRAME_END);
    send_beat(MODE_SLOT, 10'd1, 8'd1);
    send_event(MODE_FRAME_END);
    send_beat(MODE_SLOT, 10'd5, 8'd255);
    send_beat(MODE_SLOT, 10'd1, 8'd254);
    send_event(MODE_FRAME_END);
    send_event(MODE_TIMEOUT);
    wait_idle();
    run_saturated_timer();

    foreach (starts[p]) begin
      wait_idle();
      write_start(starts[p]);
      goal = beats_counted + 95;
      while (beats_counted < goal) begin
        run_frame();
        if ($urandom_range(0, 29) == 0) wait_idle();
      end
    end
    wait_idle();

    if (sb.errors == 0)
      $display("tb_dmx_rgb_dimmer_strobe_top passed");
    else
      $display("tb_dmx_rgb_dimmer_strobe_top failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_dmx_rgb_dimmer_strobe_top failed");
    $finish;
  end

endmodule
